[src/crp_pkg.sv]
`timescale 1ns / 1ps

package crp_pkg;

   // Coordinates are reduced to this many bits and taken as two's complement.
   localparam int COORD_WIDTH = 32;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;

   // Path operation codes.
   localparam logic [2:0] OP_MOVE  = 3'd0;
   localparam logic [2:0] OP_LINE  = 3'd1;
   localparam logic [2:0] OP_GHOST = 3'd2;
   localparam logic [2:0] OP_CONIC = 3'd3;
   localparam logic [2:0] OP_CUBIC = 3'd4;

   // Queue depths; both must be powers of two so the pointers wrap on their own.
   localparam int REQ_DEPTH = 4;
   localparam int REQ_PTR_W = $clog2(REQ_DEPTH);
   localparam int REQ_CNT_W = $clog2(REQ_DEPTH + 1);
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [2:0]         point_op;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               path_end;
   } point_type;

   typedef struct packed {
      logic [2:0]         kept_op;
      logic signed [31:0] kept_x;
      logic signed [31:0] kept_y;
      logic               kept_last;
   } kept_type;

   // A classified point as it travels between the front and the back.
   typedef struct packed {
      logic [2:0]                     op;
      logic                           line_op;
      logic signed [COORD_WIDTH-1:0]  x;
      logic signed [COORD_WIDTH-1:0]  y;
      logic                           last;
   } item_type;

   // Up to two results written into the result queue in one cycle.
   typedef struct packed {
      logic [1:0] count;
      kept_type   item0;
      kept_type   item1;
   } rsp_write_type;

   // How much of a path the back end currently holds.
   typedef enum logic [1:0] {
      HELD_NONE    = 2'd0,
      HELD_ANCHOR  = 2'd1,
      HELD_PENDING = 2'd2
   } held_type;

   // Exact difference of two coordinates, one bit wider.
   function automatic logic signed [DIFF_WIDTH-1:0] coord_diff(
      input logic signed [COORD_WIDTH-1:0] a,
      input logic signed [COORD_WIDTH-1:0] b
   );
      logic signed [DIFF_WIDTH-1:0] ea;
      logic signed [DIFF_WIDTH-1:0] eb;
      ea = DIFF_WIDTH'(a);
      eb = DIFF_WIDTH'(b);
      return ea - eb;
   endfunction

   // Builds a result from a stored point, sign extending its coordinates.
   function automatic kept_type to_kept(
      input logic [2:0]                    op,
      input logic signed [COORD_WIDTH-1:0] x,
      input logic signed [COORD_WIDTH-1:0] y,
      input logic                          last
   );
      kept_type k;
      k.kept_op   = op;
      k.kept_x    = 32'(x);
      k.kept_y    = 32'(y);
      k.kept_last = last;
      return k;
   endfunction

endpackage

[src/crp_front.sv]
`timescale 1ns / 1ps

module crp_front import crp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  point_type point,
   output logic      full,
   output logic      head_valid,
   output item_type  head,
   input  logic      head_pop
);

   item_type               mem_ff [REQ_DEPTH];
   logic [REQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [REQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [REQ_CNT_W-1:0]   count_ff, count_in;
   logic                   push_ok;
   logic                   pop_ok;
   item_type               classified;

   // Classify the incoming point: reduce the coordinates and mark line codes.
   always_comb begin
      classified.op      = point.point_op;
      classified.line_op = (point.point_op == OP_LINE) || (point.point_op == OP_GHOST);
      classified.x       = point.point_x[COORD_WIDTH-1:0];
      classified.y       = point.point_y[COORD_WIDTH-1:0];
      classified.last    = point.path_end;
   end

   assign full       = (count_ff == REQ_CNT_W'(REQ_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign push_ok    = push && !full;
   assign pop_ok     = head_pop && head_valid;

   // Queue pointer and fill count update.
   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + REQ_CNT_W'(push_ok) - REQ_CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

[src/crp_back.sv]
`timescale 1ns / 1ps

module crp_back import crp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  item_type      head,
   output logic          head_pop,
   input  logic          rsp_room,
   output rsp_write_type rsp_wr
);

   // Product stage.
   logic                          m_valid_ff;
   item_type                      m_item_ff;
   // Decision stage.
   logic                          d_valid_ff;
   item_type                      d_item_ff;
   logic signed [PROD_WIDTH-1:0]  d_p0_ff, d_q0_ff, d_p1_ff, d_q1_ff;
   // Path state.
   held_type                      held_ff, held_in;
   logic signed [COORD_WIDTH-1:0] anchor_x_ff, anchor_x_in;
   logic signed [COORD_WIDTH-1:0] anchor_y_ff, anchor_y_in;
   logic [2:0]                    pend_op_ff, pend_op_in;
   logic signed [COORD_WIDTH-1:0] pend_x_ff, pend_x_in;
   logic signed [COORD_WIDTH-1:0] pend_y_ff, pend_y_in;
   logic                          moved_ff, moved_in;

   logic                          adv;
   logic                          d_fire;
   logic signed [COORD_WIDTH-1:0] mid_x, mid_y, alt_x, alt_y;
   logic signed [PROD_WIDTH-1:0]  m_p0, m_q0, m_p1, m_q1;
   logic                          op_match, turn_back, axis_flat, cross_eq;
   logic                          removable, keep_pend;

   // The pipe moves as one whenever the result queue can take two results.
   assign adv      = rsp_room;
   assign head_pop = adv && head_valid;
   assign d_fire   = adv && d_valid_ff;

   // The middle point of the next test is the item now in the decision stage,
   // or the stored pending point when that stage is empty. Its anchor is
   // either today's anchor or, if the decision now being made keeps the
   // pending point, that pending point; both products are formed here.
   always_comb begin
      mid_x = d_valid_ff ? d_item_ff.x : pend_x_ff;
      mid_y = d_valid_ff ? d_item_ff.y : pend_y_ff;
      alt_x = d_valid_ff ? pend_x_ff : anchor_x_ff;
      alt_y = d_valid_ff ? pend_y_ff : anchor_y_ff;
      m_p0  = coord_diff(m_item_ff.x, anchor_x_ff) * coord_diff(mid_y, anchor_y_ff);
      m_q0  = coord_diff(m_item_ff.y, anchor_y_ff) * coord_diff(mid_x, anchor_x_ff);
      m_p1  = coord_diff(m_item_ff.x, alt_x) * coord_diff(mid_y, alt_y);
      m_q1  = coord_diff(m_item_ff.y, alt_y) * coord_diff(mid_x, alt_x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= head_valid;
         d_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_item_ff <= head;
         d_item_ff <= m_item_ff;
         d_p0_ff   <= m_p0;
         d_q0_ff   <= m_q0;
         d_p1_ff   <= m_p1;
         d_q1_ff   <= m_q1;
      end
   end

   // Window test on anchor, pending point and the new item.
   always_comb begin
      op_match  = d_item_ff.line_op && (pend_op_ff == d_item_ff.op);
      turn_back = ((anchor_x_ff < pend_x_ff) && (pend_x_ff > d_item_ff.x)) ||
                  ((anchor_x_ff > pend_x_ff) && (pend_x_ff < d_item_ff.x)) ||
                  ((anchor_y_ff < pend_y_ff) && (pend_y_ff > d_item_ff.y)) ||
                  ((anchor_y_ff > pend_y_ff) && (pend_y_ff < d_item_ff.y));
      axis_flat = ((anchor_x_ff == pend_x_ff) && (pend_x_ff == d_item_ff.x)) ||
                  ((anchor_y_ff == pend_y_ff) && (pend_y_ff == d_item_ff.y));
      cross_eq  = moved_ff ? (d_p1_ff == d_q1_ff) : (d_p0_ff == d_q0_ff);
      removable = op_match && !turn_back && (axis_flat || cross_eq);
      keep_pend = (held_ff == HELD_PENDING) && !removable;
   end

   // Next state of the path tracker.
   always_comb begin
      held_in = held_ff;
      if (d_fire) begin
         unique case (held_ff)
            HELD_NONE: begin
               held_in = d_item_ff.last ? HELD_NONE : HELD_ANCHOR;
            end
            HELD_ANCHOR, HELD_PENDING: begin
               held_in = d_item_ff.last ? HELD_NONE : HELD_PENDING;
            end
            default: begin
               held_in = HELD_NONE;
            end
         endcase
      end
   end

   // Outputs of the path tracker: stored points and the results written.
   always_comb begin
      anchor_x_in = anchor_x_ff;
      anchor_y_in = anchor_y_ff;
      pend_op_in  = pend_op_ff;
      pend_x_in   = pend_x_ff;
      pend_y_in   = pend_y_ff;
      moved_in    = moved_ff;
      rsp_wr.count = 2'd0;
      rsp_wr.item0 = to_kept(d_item_ff.op, d_item_ff.x, d_item_ff.y, d_item_ff.last);
      rsp_wr.item1 = to_kept(d_item_ff.op, d_item_ff.x, d_item_ff.y, 1'b1);
      if (d_fire) begin
         if (held_ff == HELD_NONE) begin
            // First point of a path goes out at once and becomes the anchor.
            anchor_x_in  = d_item_ff.x;
            anchor_y_in  = d_item_ff.y;
            moved_in     = 1'b0;
            rsp_wr.count = 2'd1;
         end else begin
            if (keep_pend) begin
               anchor_x_in  = pend_x_ff;
               anchor_y_in  = pend_y_ff;
               rsp_wr.item0 = to_kept(pend_op_ff, pend_x_ff, pend_y_ff, 1'b0);
            end
            pend_op_in   = d_item_ff.op;
            pend_x_in    = d_item_ff.x;
            pend_y_in    = d_item_ff.y;
            moved_in     = keep_pend;
            rsp_wr.count = 2'(keep_pend) + 2'(d_item_ff.last);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= HELD_NONE;
         moved_ff <= 1'b0;
      end else begin
         held_ff  <= held_in;
         moved_ff <= moved_in;
      end
   end

   always_ff @(posedge clock) begin
      anchor_x_ff <= anchor_x_in;
      anchor_y_ff <= anchor_y_in;
      pend_op_ff  <= pend_op_in;
      pend_x_ff   <= pend_x_in;
      pend_y_ff   <= pend_y_in;
   end

   // The first point of a path always yields exactly one result.
   a_first_point_one_result: assert property (@(posedge clock) disable iff (reset)
      (d_fire && (held_ff == HELD_NONE)) |-> (rsp_wr.count == 2'd1))
      else $error("first point of a path did not yield exactly one result");

   // An end mark always closes the path.
   a_end_closes_path: assert property (@(posedge clock) disable iff (reset)
      (d_fire && d_item_ff.last) |=> (held_ff == HELD_NONE))
      else $error("path still open after its end mark");

   // Results are written only when an item leaves the decision stage.
   a_write_only_on_decision: assert property (@(posedge clock) disable iff (reset)
      !d_fire |-> (rsp_wr.count == 2'd0))
      else $error("result written without a decision");

endmodule

[src/crp_rsp_queue.sv]
`timescale 1ns / 1ps

module crp_rsp_queue import crp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  rsp_write_type wr,
   output logic          room,
   input  logic          pop,
   output logic          empty,
   output kept_type      kept
);

   kept_type             mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic [RSP_PTR_W-1:0] wr_ptr_next;
   logic                 pop_ok;

   // Room for two results, the most one decision can write.
   assign room        = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign empty       = (count_ff == '0);
   assign kept        = mem_ff[rd_ptr_ff];
   assign pop_ok      = pop && !empty;
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(wr.count);
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(wr.count) - RSP_CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage: the first result at the write pointer, a second one after it.
   always_ff @(posedge clock) begin
      if (wr.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= wr.item0;
      end
      if (wr.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= wr.item1;
      end
   end

endmodule

[src/collinear_point_remover.sv]
`timescale 1ns / 1ps

// Removes collinear middle points from a stream of path points. A point is
// dropped when it and the next point both carry the same line or ghost-line
// operation, neither x nor y turns back at it, and it lies exactly on the line
// from the last kept point to the next point (exact cross product on Q16.16
// coordinates). The first point of a path comes out at once; a later point is
// held until the next one decides its fate, and the end mark flushes it. One
// point is accepted every clock as long as results are taken; a point's
// results leave the decision stage, after the request queue and product stage.
// The rate is set by the decision stage, which finishes one point per cycle:
// the two cross products for the following point are formed a stage ahead for
// both possible anchors, and the decision only selects between them.
// A four-entry queue on each side absorbs stalls; no clearing pass after reset.
module collinear_point_remover import crp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  point_type req_point,
   output logic      full,
   input  logic      pop,
   output kept_type  rsp_kept,
   output logic      empty
);

   logic          head_valid;
   item_type      head;
   logic          head_pop;
   logic          rsp_room;
   rsp_write_type rsp_wr;

   crp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .point      (req_point),
      .full       (full),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop)
   );

   crp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_room   (rsp_room),
      .rsp_wr     (rsp_wr)
   );

   crp_rsp_queue u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .wr    (rsp_wr),
      .room  (rsp_room),
      .pop   (pop),
      .empty (empty),
      .kept  (rsp_kept)
   );

endmodule

[test/tb_collinear_point_remover.sv]
`timescale 1ns / 1ps

module tb_collinear_point_remover;
   import crp_pkg::*;

   // Operation codes that the block must pass through untouched.
   localparam logic [2:0] OP_SPARE5 = 3'd5;
   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;

   localparam int COORD_MIN   = 32'sh8000_0000;
   localparam int COORD_MAX   = 32'sh7fff_ffff;
   localparam int POINT_TOTAL = 750;
   localparam int MAX_GAP     = 12;
   localparam int LONG_HOLD   = 300;
   localparam int HOLD_AT     = 60;
   localparam int DRAIN_EVERY = 40;
   localparam int TAIL_CYCLES = 20;
   localparam int MAX_PRINTED = 100;

   // Tracks the expected kept points and compares them with what comes out.
   class kept_scoreboard;
      kept_type           expected_q[$];
      held_type           held;
      logic signed [31:0] anchor_x;
      logic signed [31:0] anchor_y;
      logic [2:0]         pending_op;
      logic signed [31:0] pending_x;
      logic signed [31:0] pending_y;
      int                 errors;

      function new();
         held       = HELD_NONE;
         anchor_x   = '0;
         anchor_y   = '0;
         pending_op = '0;
         pending_x  = '0;
         pending_y  = '0;
         errors     = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Keeps the low COORD_WIDTH bits and sign extends them back to 32.
      function logic signed [31:0] to_coord(logic [31:0] v);
         logic signed [COORD_WIDTH-1:0] r;
         r = v[COORD_WIDTH-1:0];
         return 32'(r);
      endfunction

      function void push_kept(logic [2:0] op, logic signed [31:0] x,
                              logic signed [31:0] y, logic last);
         kept_type k;
         k.kept_op   = op;
         k.kept_x    = x;
         k.kept_y    = y;
         k.kept_last = last;
         expected_q.push_back(k);
      endfunction

      // Decides whether the pending point can go, given the next point.
      function bit is_droppable(logic [2:0] op, logic signed [31:0] x,
                                logic signed [31:0] y);
         logic signed [33:0] d_cx;
         logic signed [33:0] d_by;
         logic signed [33:0] d_cy;
         logic signed [33:0] d_bx;
         logic signed [67:0] lhs;
         logic signed [67:0] rhs;
         if (pending_op != op || (op != OP_LINE && op != OP_GHOST)) return 1'b0;
         if (anchor_x < pending_x && pending_x > x) return 1'b0;
         if (anchor_x > pending_x && pending_x < x) return 1'b0;
         if (anchor_y < pending_y && pending_y > y) return 1'b0;
         if (anchor_y > pending_y && pending_y < y) return 1'b0;
         if ((anchor_x == pending_x && pending_x == x) ||
             (anchor_y == pending_y && pending_y == y)) return 1'b1;
         // Exact cross product on widened differences.
         d_cx = 34'(x) - 34'(anchor_x);
         d_by = 34'(pending_y) - 34'(anchor_y);
         d_cy = 34'(y) - 34'(anchor_y);
         d_bx = 34'(pending_x) - 34'(anchor_x);
         lhs  = 68'(d_cx) * 68'(d_by);
         rhs  = 68'(d_cy) * 68'(d_bx);
         return lhs == rhs;
      endfunction

      // Advances the path state by one accepted point.
      function void note_point(point_type p);
         logic [2:0]         op;
         logic signed [31:0] x;
         logic signed [31:0] y;
         op = p.point_op;
         x  = to_coord(p.point_x);
         y  = to_coord(p.point_y);
         if (held == HELD_NONE) begin
            push_kept(op, x, y, p.path_end);
            anchor_x = x;
            anchor_y = y;
            held     = p.path_end ? HELD_NONE : HELD_ANCHOR;
         end else begin
            if (held == HELD_PENDING && !is_droppable(op, x, y)) begin
               push_kept(pending_op, pending_x, pending_y, 1'b0);
               anchor_x = pending_x;
               anchor_y = pending_y;
            end
            pending_op = op;
            pending_x  = x;
            pending_y  = y;
            held       = HELD_PENDING;
            if (p.path_end) begin
               push_kept(pending_op, pending_x, pending_y, 1'b1);
               held = HELD_NONE;
            end
         end
      endfunction

      task report(string msg);
         if (errors < MAX_PRINTED) begin
            $display("ERROR at %0t ns: %s", $time, msg);
         end
         errors++;
      endtask

      // Compares one accepted item with the oldest expected one.
      task check_kept(kept_type got);
         kept_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected item op=%0d x=%h y=%h last=%0d",
                             got.kept_op, got.kept_x, got.kept_y, got.kept_last));
         end else begin
            want = expected_q.pop_front();
            if (got.kept_op !== want.kept_op)
               report($sformatf("kept_op %0d, expected %0d", got.kept_op, want.kept_op));
            if (got.kept_x !== want.kept_x)
               report($sformatf("kept_x %h, expected %h", got.kept_x, want.kept_x));
            if (got.kept_y !== want.kept_y)
               report($sformatf("kept_y %h, expected %h", got.kept_y, want.kept_y));
            if (got.kept_last !== want.kept_last)
               report($sformatf("kept_last %0d, expected %0d",
                                got.kept_last, want.kept_last));
         end
      endtask
   endclass

   logic      clock = 1'b0;
   logic      reset;
   logic      push;
   point_type req_point;
   logic      full;
   logic      pop;
   kept_type  rsp_kept;
   logic      empty;

   kept_scoreboard sb;
   bit             req_steady;
   bit             rsp_steady;
   int             points_sent;

   collinear_point_remover u_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_point (req_point),
      .full      (full),
      .pop       (pop),
      .rsp_kept  (rsp_kept),
      .empty     (empty)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function int draw_gap(bit steady);
      return steady ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function point_type make_point(logic [2:0] op, int x, int y, logic last);
      point_type p;
      p.point_op = op;
      p.point_x  = x;
      p.point_y  = y;
      p.path_end = last;
      return p;
   endfunction

   function int pick_extreme();
      case ($urandom_range(0, 4))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return 0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   // Offers one point after a random gap and waits until it is taken. The push
   // stays high between back-to-back items and is only lowered for a gap.
   task send_point(point_type p);
      int gap;
      gap = draw_gap(req_steady);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push      <= 1'b1;
      req_point <= p;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.note_point(p);
      points_sent++;
   endtask

   // Stops offering items until every expected item has come out.
   task wait_drained();
      push <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // One random path: mostly points on a line with random content, plus
   // turn-backs, axis runs, extremes, wrapping lines and broken sequences.
   task send_path();
      int         len;
      int         style;
      int         bx;
      int         by;
      int         dx;
      int         dy;
      int         k;
      int         i;
      int         x;
      int         y;
      logic [2:0] path_op;
      logic [2:0] op;
      logic       last;
      len     = $urandom_range(1, 8);
      style   = $urandom_range(0, 9);
      path_op = ($urandom_range(0, 1) == 0) ? OP_LINE : OP_GHOST;
      bx      = int'($urandom_range(0, 2097152)) - 1048576;
      by      = int'($urandom_range(0, 2097152)) - 1048576;
      dx      = int'($urandom_range(0, 512)) - 256;
      dy      = int'($urandom_range(0, 512)) - 256;
      if (style == 6) begin
         if ($urandom_range(0, 1) == 0) dx = 0;
         else dy = 0;
      end
      if (style == 9) begin
         bx = $urandom;
         by = $urandom;
         dx = $urandom;
         dy = $urandom;
      end
      k = 0;
      for (i = 0; i < len; i++) begin
         // Point position along the line, or free values for noise styles.
         if (style == 5) k = k + int'($urandom_range(0, 5)) - 2;
         else k = k + int'($urandom_range(0, 3));
         x = bx + k * dx;
         y = by + k * dy;
         if (style == 7) begin
            x = $urandom;
            y = $urandom;
         end
         if (style == 8) begin
            x = pick_extreme();
            y = pick_extreme();
         end
         // Operation: move first, then the path's line code, with some noise.
         if (i == 0) op = OP_MOVE;
         else op = path_op;
         if ($urandom_range(0, 19) < 3) op = 3'($urandom_range(0, 7));
         last = (i == len - 1) || ($urandom_range(0, 19) == 0);
         send_point(make_point(op, x, y, last));
      end
   endtask

   // Takes results after random gaps and holds off once for a long stretch.
   task take_results();
      int gap;
      int seen;
      seen = 0;
      forever begin
         gap = (seen == HOLD_AT) ? LONG_HOLD : draw_gap(rsp_steady);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         sb.check_kept(rsp_kept);
         seen++;
         if (seen % 32 == 0) rsp_steady = ($urandom_range(0, 3) == 0);
      end
   endtask

   // Watchdog for a hung run.
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int paths;
      reset       <= 1'b1;
      push        <= 1'b0;
      req_point   <= '0;
      pop         <= 1'b0;
      sb          = new();
      req_steady  = 1'b0;
      rsp_steady  = 1'b0;
      points_sent = 0;
      paths       = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      fork
         take_results();
      join_none

      // Single-point path.
      send_point(make_point(OP_MOVE, 0, 0, 1'b1));
      // Diagonal run whose middle points drop.
      send_point(make_point(OP_MOVE, 0, 0, 1'b0));
      send_point(make_point(OP_LINE, 1, 1, 1'b0));
      send_point(make_point(OP_LINE, 2, 2, 1'b0));
      send_point(make_point(OP_LINE, 3, 3, 1'b1));
      // Ghost lines across the full coordinate range.
      send_point(make_point(OP_MOVE, COORD_MIN, COORD_MIN, 1'b0));
      send_point(make_point(OP_GHOST, 0, 0, 1'b0));
      send_point(make_point(OP_GHOST, COORD_MAX, COORD_MAX, 1'b1));
      // Vertical run, then a turn back.
      send_point(make_point(OP_MOVE, 5, 0, 1'b0));
      send_point(make_point(OP_LINE, 5, 10, 1'b0));
      send_point(make_point(OP_LINE, 5, 20, 1'b0));
      send_point(make_point(OP_LINE, 5, -5, 1'b1));
      // Line followed by ghost line on the same line is kept.
      send_point(make_point(OP_MOVE, 0, 0, 1'b0));
      send_point(make_point(OP_LINE, 10, 0, 1'b0));
      send_point(make_point(OP_GHOST, 20, 0, 1'b1));
      // Curve and unused codes pass through.
      send_point(make_point(OP_MOVE, 0, 0, 1'b0));
      send_point(make_point(OP_CONIC, 1, 1, 1'b0));
      send_point(make_point(OP_CUBIC, 2, 2, 1'b0));
      send_point(make_point(OP_SPARE5, 3, 3, 1'b0));
      send_point(make_point(OP_SPARE6, 4, 4, 1'b0));
      send_point(make_point(OP_SPARE7, 5, 5, 1'b1));
      // Moveto inside a path.
      send_point(make_point(OP_MOVE, 0, 0, 1'b0));
      send_point(make_point(OP_LINE, 1, 2, 1'b0));
      send_point(make_point(OP_MOVE, 2, 4, 1'b0));
      send_point(make_point(OP_LINE, 3, 6, 1'b1));
      wait_drained();

      // Random paths, with a full drain now and then.
      while (points_sent < POINT_TOTAL) begin
         req_steady = ($urandom_range(0, 3) == 0);
         send_path();
         paths++;
         if (paths % DRAIN_EVERY == 0) wait_drained();
      end

      push <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[files.f]
src/crp_pkg.sv
src/crp_front.sv
src/crp_back.sv
src/crp_rsp_queue.sv
src/collinear_point_remover.sv
test/tb_collinear_point_remover.sv
